// File: rtl/core/clea_pkg.sv
// clea_pkg: shared constants, types and a helper function for the circular log
// entry allocator. Used by every module under rtl/core but clea_ram; depends on nothing.
package clea_pkg;

  localparam int LOG_BYTES     = 4096;
  localparam int LINE_BYTES    = 64;
  localparam int HEADER_BYTES  = 16;
  localparam int MAX_RESULTS   = 64;
  localparam int LOG_MIN_BYTES = (LINE_BYTES > 64) ? LINE_BYTES : 64;

  localparam int OFF_W      = $clog2(LOG_BYTES);
  localparam int SIZE_W     = OFF_W + 1;
  localparam int LINE_SH    = $clog2(LINE_BYTES);
  localparam int NUM_LINES  = LOG_BYTES / LINE_BYTES;
  localparam int LINE_IDX_W = OFF_W - LINE_SH;
  localparam int CNT_W      = $clog2(MAX_RESULTS);
  localparam int OBJ_W      = 16;
  localparam int CNTR_W     = 32;
  localparam int ESZ_W      = OBJ_W + 1;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = ST_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ      = 3'd0,
    OP_DEQ      = 3'd1,
    OP_PTAIL    = 3'd2,
    OP_PHEAD    = 3'd3,
    OP_SET_TAIL = 3'd4,
    OP_SET_HEAD = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DEQ   = 2'd1,
    BK_FLUSH = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [ESZ_W-1:0]  ebytes;
    logic [CNTR_W-1:0] new_count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // clamp to [LOG_MIN_BYTES, LOG_BYTES] and round up to a power of two
  function automatic logic [SIZE_W-1:0] effective_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    res = SIZE_W'(LOG_BYTES);
    for (int k = $clog2(LOG_BYTES); k >= $clog2(LOG_MIN_BYTES); k--) begin
      if (v <= SIZE_W'(1 << k)) res = SIZE_W'(1 << k);
    end
    return res;
  endfunction

endpackage

// File: rtl/core/clea_ram.sv
// clea_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module clea_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/clea_front.sv
// clea_front: input side of the allocator; decodes the operation and rounds
// the enqueue size up to whole lines. Depends on clea_pkg.
module clea_front import clea_pkg::*; (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [IN_TUSER_W-1:0] s_axis_tuser,
  input  q_stat_t               q_stat_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [OBJ_W-1:0] obj;
  logic [ESZ_W-1:0] sum;

  assign obj = s_axis_tdata[OBJ_W-1:0];
  // size plus header, rounded up to the next line boundary
  assign sum = ESZ_W'(obj) + ESZ_W'(HEADER_BYTES + LINE_BYTES - 1);

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    cmd_o.op        = op_e'(s_axis_tuser);
    cmd_o.ebytes    = sum & ~ESZ_W'(LINE_BYTES - 1);
    cmd_o.new_count = s_axis_tdata[OBJ_W +: CNTR_W];
  end

endmodule

// File: rtl/core/clea_fifo.sv
// clea_fifo: short command queue between the front and back parts.
// Depends on clea_pkg for cmd_t and queue status.
module clea_fifo import clea_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t q_stat_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (pop_i)  rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= cmd_i;
  end

  assign cmd_o          = mem_q[rptr_q];
  assign q_stat_o.full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign q_stat_o.empty = (cnt_q == '0);

endmodule

// File: rtl/core/clea_back.sv
// clea_back: executes queued commands against the head/tail counters and the
// per-line size store, and drives the result register. Depends on clea_pkg
// and clea_ram.
module clea_back import clea_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i,
  input  q_stat_t                q_stat_i,
  input  cmd_t                   cmd_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  back_state_e       state_q, state_d;
  logic [CNTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNTR_W-1:0] shead_q, shead_d, stail_q, stail_d;
  logic [SIZE_W-1:0] eff_q, eff_d;
  logic [NUM_LINES-1:0] vld_q, vld_d;
  logic              deq_vld_q, deq_vld_d;
  logic [OFF_W-1:0]  fl_i_q, fl_i_d;
  logic              fl_wrap_q, fl_wrap_d;
  logic [CNT_W-1:0]  fl_cnt_q, fl_cnt_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [OFF_W-1:0]  out_off_q, out_foff_q;
  logic [SIZE_W-1:0] out_bytes_q;
  logic              out_fv_q, out_hs_q, out_last_q;

  logic              emit, can_emit, done;
  status_e           e_status;
  logic [OFF_W-1:0]  e_off, e_foff;
  logic [SIZE_W-1:0] e_bytes, sz, nxt;
  logic              e_fv, e_hs, e_last;

  logic [OFF_W-1:0]  mask, head_idx, tail_idx, stail_idx;
  logic [CNTR_W-1:0] occ, room;
  logic              refuse;

  logic              ram_we, ram_re;
  logic [SIZE_W-1:0] ram_rdata;

  assign mask      = OFF_W'(eff_q - SIZE_W'(1));
  assign head_idx  = head_q[OFF_W-1:0] & mask;
  assign tail_idx  = tail_q[OFF_W-1:0] & mask;
  assign stail_idx = stail_q[OFF_W-1:0] & mask;

  // occupancy plus the new entry, modulo the counter width
  assign occ    = tail_q - head_q;
  assign room   = occ + CNTR_W'(cmd_i.ebytes);
  assign refuse = (cmd_i.ebytes > ESZ_W'(eff_q)) || (room > CNTR_W'(eff_q));

  assign can_emit = !out_valid_q || m_axis_tready;

  clea_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (NUM_LINES)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_idx[OFF_W-1:LINE_SH]),
    .wdata_i (cmd_i.ebytes[SIZE_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (head_idx[OFF_W-1:LINE_SH]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    shead_d   = shead_q;
    stail_d   = stail_q;
    eff_d     = eff_q;
    vld_d     = vld_q;
    deq_vld_d = deq_vld_q;
    fl_i_d    = fl_i_q;
    fl_wrap_d = fl_wrap_q;
    fl_cnt_d  = fl_cnt_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    emit      = 1'b0;
    done      = 1'b0;
    e_status  = ST_OK;
    e_off     = '0;
    e_bytes   = '0;
    e_fv      = 1'b0;
    e_foff    = '0;
    e_hs      = 1'b0;
    e_last    = 1'b1;
    sz        = '0;
    nxt       = '0;

    if (cfg_we_i) eff_d = effective_size(cfg_wdata_i);

    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty && can_emit) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_ENQ: begin
              emit = 1'b1;
              if (refuse) begin
                e_status = ST_OVERFLOW;
              end else begin
                ram_we = 1'b1;
                vld_d[tail_idx[OFF_W-1:LINE_SH]] = 1'b1;
                tail_d  = tail_q + CNTR_W'(cmd_i.ebytes);
                e_off   = tail_idx;
                e_bytes = cmd_i.ebytes[SIZE_W-1:0];
              end
            end
            OP_DEQ: begin
              if (head_q == tail_q) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                deq_vld_d = vld_q[head_idx[OFF_W-1:LINE_SH]];
                state_d   = BK_DEQ;
              end
            end
            OP_PTAIL: begin
              if (stail_idx == tail_idx) begin
                emit = 1'b1;
              end else begin
                fl_i_d    = stail_idx;
                fl_wrap_d = (stail_idx > tail_idx);
                fl_cnt_d  = '0;
                stail_d   = tail_q;
                state_d   = BK_FLUSH;
              end
            end
            OP_PHEAD: begin
              emit    = 1'b1;
              e_hs    = (shead_q != head_q);
              shead_d = head_q;
            end
            OP_SET_TAIL: begin
              emit    = 1'b1;
              tail_d  = cmd_i.new_count;
              stail_d = cmd_i.new_count;
            end
            OP_SET_HEAD: begin
              emit    = 1'b1;
              head_d  = cmd_i.new_count;
              shead_d = cmd_i.new_count;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_DEQ: begin
        if (can_emit) begin
          // a line never written reads as size zero
          sz      = deq_vld_q ? ram_rdata : '0;
          emit    = 1'b1;
          head_d  = head_q + CNTR_W'(sz);
          e_off   = head_idx;
          e_bytes = sz;
          state_d = BK_IDLE;
        end
      end
      BK_FLUSH: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_fv     = 1'b1;
          e_foff   = fl_i_q & ~OFF_W'(LINE_BYTES - 1);
          nxt      = SIZE_W'(fl_i_q) + SIZE_W'(LINE_BYTES);
          fl_cnt_d = fl_cnt_q + 1'b1;
          if (fl_wrap_q) begin
            // first leg runs to the log end, second leg from zero
            if (nxt >= eff_q) begin
              if (tail_idx == '0) begin
                done = 1'b1;
              end else begin
                fl_wrap_d = 1'b0;
                fl_i_d    = '0;
              end
            end else begin
              fl_i_d = nxt[OFF_W-1:0];
            end
          end else begin
            if (nxt >= SIZE_W'(tail_idx)) done = 1'b1;
            else fl_i_d = nxt[OFF_W-1:0];
          end
          if (fl_cnt_q == CNT_W'(MAX_RESULTS - 1)) done = 1'b1;
          e_last = done;
          if (done) state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    out_valid_d = emit || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      shead_q     <= '0;
      stail_q     <= '0;
      eff_q       <= SIZE_W'(LOG_BYTES);
      vld_q       <= '0;
      deq_vld_q   <= 1'b0;
      fl_i_q      <= '0;
      fl_wrap_q   <= 1'b0;
      fl_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      shead_q     <= shead_d;
      stail_q     <= stail_d;
      eff_q       <= eff_d;
      vld_q       <= vld_d;
      deq_vld_q   <= deq_vld_d;
      fl_i_q      <= fl_i_d;
      fl_wrap_q   <= fl_wrap_d;
      fl_cnt_q    <= fl_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= e_status;
      out_off_q    <= e_off;
      out_bytes_q  <= e_bytes;
      out_fv_q     <= e_fv;
      out_foff_q   <= e_foff;
      out_hs_q     <= e_hs;
      out_last_q   <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_hs_q, out_foff_q, out_bytes_q, out_off_q};
  assign m_axis_tuser  = {out_fv_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/circular_log_entry_allocator_unit.sv
// circular_log_entry_allocator_unit: top level of the circular log entry
// allocator. Depends on clea_pkg, clea_front, clea_fifo and clea_back.
//
// Usage:
//   s_axis carries one operation per transaction: tuser is the op code,
//   tdata holds the object size and a new counter value. m_axis returns
//   one or more results per operation, tlast on the final one.
//   cfg_we_i/cfg_wdata_i set the log size in bytes; write only while idle.
// Execution:
//   a transaction enters a two-entry command queue; enqueue, empty dequeue,
//   persist head, the set commands and a persist tail with nothing to flush
//   emit straight from the queue head; a dequeue first reads the size store
//   (registered read data), then emits; a persist tail with lines to flush
//   sets up its range, then emits one line per cycle unless m_axis stalls.
// Reset:
//   counters and saved copies clear to zero, log size returns to 4096 bytes;
//   the size store is masked by one valid flag per line, so no clearing pass.
// Stall:
//   when m_axis_tready is low with a result pending, that result holds and
//   execution waits; the queue accepts until full, then s_axis_tready drops.
module circular_log_entry_allocator_unit import clea_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_wdata_i,   // log_bytes_in_use
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // object_bytes[15:0], new_count[47:16]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[2:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // entry_offset[11:0], entry_bytes[24:12], flush_offset[36:25],
  // head_saved[37], zero fill[39:38]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0], flush_valid[2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  q_stat_t q_stat;
  cmd_t    push_cmd, head_cmd;
  logic    push, pop;

  clea_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  clea_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .q_stat_o (q_stat)
  );

  clea_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_stat_i      (q_stat),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_flush_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[OUT_TUSER_W-1]) |-> (m_axis_tuser[ST_W-1:0] == ST_OK))
    else $error("flush result with non-ok status");

  a_flush_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[OUT_TUSER_W-1]) |-> (m_axis_tdata[24:0] == '0))
    else $error("flush result carries entry fields");
`endif

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for circular_log_entry_allocator_unit. It runs a
// directed table, then random phases over several log sizes, with its own log predictor.
// Depends on clea_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module testbench;
  import clea_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
  localparam logic [OFF_W-1:0] LINE_MASK = ~OFF_W'(LINE_BYTES - 1);
  // longest quiet stretch is the long receiver hold
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 80;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_DIR_ROWS = 27;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [OFF_W-1:0] off;
    logic [SIZE_W-1:0] bytes;
    logic             fv;
    logic [OFF_W-1:0] foff;
    logic             hs;
    logic             last;
  } log_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [OBJ_W-1:0]  obj;
    logic [CNTR_W-1:0] nc;
    logic              typed;
    logic [ST_W-1:0]   st;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] bytes;
    logic              hs;
  } dir_row_t;

  // typed rows carry the whole expected result; the others go through the predictor
  localparam dir_row_t OP_TABLE [NUM_DIR_ROWS] = '{
    '{OP_DEQ,      16'd0,    32'h0,         1'b1, ST_EMPTY,    12'h0, 13'd0,  1'b0},
    '{OP_PTAIL,    16'd0,    32'h0,         1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_PHEAD,    16'd0,    32'h0,         1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_ENQ,      16'd0,    32'h0,         1'b1, ST_OK,       12'h0, 13'd64, 1'b0},
    '{OP_ENQ,      16'hFFFF, 32'h0,         1'b1, ST_OVERFLOW, 12'h0, 13'd0,  1'b0},
    '{OP_ENQ,      16'd4080, 32'h0,         1'b1, ST_OVERFLOW, 12'h0, 13'd0,  1'b0},
    '{OP_ENQ,      16'd48,   32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_DEQ,      16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_PTAIL,    16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_PHEAD,    16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_RSVD_LO,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_RSVD_HI,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_TAIL, 16'd0,    32'hFFFF_FFC0, 1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_HEAD, 16'd0,    32'hFFFF_FFC0, 1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_ENQ,      16'd100,  32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_PTAIL,    16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_DEQ,      16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_DEQ,      16'd0,    32'h0,         1'b1, ST_EMPTY,    12'h0, 13'd0,  1'b0},
    '{OP_SET_HEAD, 16'd0,    32'h280,       1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_DEQ,      16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_TAIL, 16'd0,    32'h7F,        1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_HEAD, 16'd0,    32'h7F,        1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_ENQ,      16'd4000, 32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_PTAIL,    16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_DEQ,      16'd0,    32'h0,         1'b0, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_TAIL, 16'd0,    32'h0,         1'b1, ST_OK,       12'h0, 13'd0,  1'b0},
    '{OP_SET_HEAD, 16'd0,    32'h0,         1'b1, ST_OK,       12'h0, 13'd0,  1'b0}
  };

  localparam logic [SIZE_W-1:0] PHASE_LOG_SIZE [NUM_PHASES] = '{
    13'd1000, 13'd64, 13'd8191, 13'd0, 13'd100, 13'd2048
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [SIZE_W-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // predictor state
  logic [CNTR_W-1:0] pred_head, pred_tail, head_kept, tail_kept;
  logic [SIZE_W-1:0] line_size [NUM_LINES];
  logic [31:0]       log_span;

  log_result_t pending_results [$];
  log_result_t got, want;
  int  mismatch_count, items_sent, results_seen, flush_lines, overflows, empties;
  int  quiet_cycles;
  bit  idle_on, long_hold_req;

  circular_log_entry_allocator_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // clamp to the legal range, then round up to a power of two
  function automatic logic [31:0] log_span_of(logic [SIZE_W-1:0] v);
    logic [31:0] p;
    p = LOG_MIN_BYTES;
    while (p < 32'(v) && p < LOG_BYTES) p = p << 1;
    return p;
  endfunction

  task automatic compute_log_results(input logic [OP_W-1:0] op, input logic [OBJ_W-1:0] obj,
                                     input logic [CNTR_W-1:0] nc);
    log_result_t r;
    logic [31:0] need, idx, live, kept, i;
    int n;
    r = '0;
    n = 0;
    case (op)
      OP_ENQ: begin
        need = (32'(obj) + HEADER_BYTES + LINE_BYTES - 1) / LINE_BYTES * LINE_BYTES;
        if (need > log_span || pred_tail + need - pred_head > log_span) begin
          r.st = ST_OVERFLOW;
        end else begin
          idx = pred_tail & (log_span - 1);
          line_size[idx / LINE_BYTES % NUM_LINES] = need[SIZE_W-1:0];
          pred_tail += need;
          r.off = idx[OFF_W-1:0];
          r.bytes = need[SIZE_W-1:0];
        end
      end
      OP_DEQ: begin
        if (pred_head == pred_tail) begin
          r.st = ST_EMPTY;
        end else begin
          idx = pred_head & (log_span - 1);
          r.bytes = line_size[idx / LINE_BYTES % NUM_LINES];
          pred_head += 32'(r.bytes);
          r.off = idx[OFF_W-1:0];
        end
      end
      OP_PTAIL: begin
        live = pred_tail & (log_span - 1);
        kept = tail_kept & (log_span - 1);
        if (kept != live) begin
          r.fv = 1'b1;
          if (kept < live) begin
            for (i = kept; i < live && n < MAX_RESULTS; i += LINE_BYTES) begin
              r.foff = i[OFF_W-1:0] & LINE_MASK;
              pending_results.push_back(r);
              n++;
            end
          end else begin
            // run to the end of the log, then wrap to offset zero
            for (i = kept; i < log_span && n < MAX_RESULTS; i += LINE_BYTES) begin
              r.foff = i[OFF_W-1:0] & LINE_MASK;
              pending_results.push_back(r);
              n++;
            end
            for (i = 0; i < live && n < MAX_RESULTS; i += LINE_BYTES) begin
              r.foff = i[OFF_W-1:0] & LINE_MASK;
              pending_results.push_back(r);
              n++;
            end
          end
          tail_kept = pred_tail;
        end
      end
      OP_PHEAD: begin
        r.hs = (head_kept != pred_head);
        head_kept = pred_head;
      end
      OP_SET_TAIL: begin
        pred_tail = nc;
        tail_kept = nc;
      end
      OP_SET_HEAD: begin
        pred_head = nc;
        head_kept = nc;
      end
      default: ;
    endcase
    if (n == 0) pending_results.push_back(r);
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endtask

  // offer one operation, predict it once accepted, maybe leave a gap afterwards
  task automatic send_op(input logic [OP_W-1:0] op, input logic [OBJ_W-1:0] obj,
                         input logic [CNTR_W-1:0] nc, input bit use_fixed,
                         input log_result_t fixed);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nc, obj};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    compute_log_results(op, obj, nc);
    if (use_fixed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(fixed);
    end
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_op();
    int pick;
    logic [OBJ_W-1:0]  obj;
    logic [CNTR_W-1:0] nc;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) obj = OBJ_W'($urandom);
    else obj = OBJ_W'($urandom_range(0, log_span - HEADER_BYTES));
    nc = $urandom;
    // counters close to the 32-bit wrap
    if ($urandom_range(0, 3) == 0) nc = 32'hFFFF_F000 | $urandom_range(0, 4095);
    if (pick < 36) begin
      send_op(OP_ENQ, obj, nc, 1'b0, '0);
    end else if (pick < 66) begin
      send_op(OP_DEQ, obj, nc, 1'b0, '0);
    end else if (pick < 78) begin
      send_op(OP_PTAIL, obj, nc, 1'b0, '0);
    end else if (pick < 86) begin
      send_op(OP_PHEAD, obj, nc, 1'b0, '0);
    end else if (pick < 92) begin
      send_op(OP_SET_TAIL, obj, nc, 1'b0, '0);
      send_op(OP_SET_HEAD, obj, nc, 1'b0, '0);
    end else if (pick < 95) begin
      send_op(OP_SET_TAIL, obj, nc, 1'b0, '0);
    end else if (pick < 98) begin
      send_op(OP_SET_HEAD, obj, nc, 1'b0, '0);
    end else begin
      send_op(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), obj, nc, 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatch_count < 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.st    = m_axis_tuser[1:0];
      got.fv    = m_axis_tuser[2];
      got.off   = m_axis_tdata[11:0];
      got.bytes = m_axis_tdata[24:12];
      got.foff  = m_axis_tdata[36:25];
      got.hs    = m_axis_tdata[37];
      got.last  = m_axis_tlast;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.st, got.st);
        check_field("entry_offset", want.off, got.off);
        check_field("entry_bytes", want.bytes, got.bytes);
        check_field("flush_valid", want.fv, got.fv);
        check_field("flush_offset", want.foff, got.foff);
        check_field("head_saved", want.hs, got.hs);
        check_field("last", want.last, got.last);
        check_field("zero fill", 0, m_axis_tdata[39:38]);
        if (want.fv) flush_lines++;
        if (want.st == ST_OVERFLOW) overflows++;
        if (want.st == ST_EMPTY) empties++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold to back the block up
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    log_result_t fixed;
    logic [CNTR_W-1:0] base;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    pred_head = '0;
    pred_tail = '0;
    head_kept = '0;
    tail_kept = '0;
    foreach (line_size[k]) line_size[k] = '0;
    log_span = log_span_of(13'd4096);
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int k = 0; k < NUM_DIR_ROWS; k++) begin
      fixed       = '0;
      fixed.st    = OP_TABLE[k].st;
      fixed.off   = OP_TABLE[k].off;
      fixed.bytes = OP_TABLE[k].bytes;
      fixed.hs    = OP_TABLE[k].hs;
      fixed.last  = 1'b1;
      send_op(OP_TABLE[k].op, OP_TABLE[k].obj, OP_TABLE[k].nc, OP_TABLE[k].typed, fixed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= PHASE_LOG_SIZE[p];
      log_span = log_span_of(PHASE_LOG_SIZE[p]);
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      idle_on = (p != NUM_PHASES - 1);
      if (p == 0) long_hold_req = 1'b1;
      // start each phase from an empty log at a random position
      base = $urandom;
      send_op(OP_SET_TAIL, '0, base, 1'b0, '0);
      send_op(OP_SET_HEAD, '0, base, 1'b0, '0);
      repeat (PHASE_ITEMS) send_random_op();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d operations over %0d log sizes, %0d results checked", items_sent,
             NUM_PHASES + 1, results_seen);
    $display("%0d flushed lines, %0d refused entries, %0d empty dequeues, %0d mismatches",
             flush_lines, overflows, empties, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
